/* rtl/mqtt_packet_deframer_unit_defines.svh */
// Assertion macros used by the deframer parse stage, mpd_parse.
`ifndef MQTT_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define MQTT_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define MPD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("mpd: invariant violated");

// Consequent must hold in the clock after the antecedent.
`define MPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mpd: sequence check failed");

// Consequent must hold in the same clock as the antecedent.
`define MPD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mpd: implication check failed");

`endif

/* rtl/mpd_pkg.sv */
package mpd_pkg;

    localparam int RX_W     = 8;
    localparam int ROLE_W   = 3;
    localparam int NIB_W    = 4;
    localparam int RLEN_W   = 28;
    localparam int TLEN_W   = 16;
    localparam int ERR_W    = 2;
    localparam int TDATA_W  = 56;
    localparam int TUSER_W  = ROLE_W + ERR_W;

    // Byte roles.
    localparam logic [ROLE_W-1:0] ROLE_FIRST   = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_TLEN    = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC   = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_BODY    = 3'd5;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_LENGTH = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOPIC_OVER = 2'd2;

    typedef struct packed {
        logic [ROLE_W-1:0] byte_role;
        logic [NIB_W-1:0]  packet_type;
        logic [NIB_W-1:0]  header_flags;
        logic [RLEN_W-1:0] remaining_length;
        logic [TLEN_W-1:0] topic_length;
        logic              packet_end;
        logic [ERR_W-1:0]  error_code;
    } result_t;

endpackage

/* rtl/mpd_in_stage.sv */
module mpd_in_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [mpd_pkg::RX_W-1:0] s_tdata,
    input  logic                     take,
    output logic                     byte_valid,
    output logic [mpd_pkg::RX_W-1:0] byte_data
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [mpd_pkg::RX_W-1:0] data_reg;

    // Refill in the same cycle the held byte moves on.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

/* rtl/mpd_parse.sv */
`include "mqtt_packet_deframer_unit_defines.svh"

module mpd_parse (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic [mpd_pkg::RX_W-1:0] rx_byte,
    output mpd_pkg::result_t         result
);

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_TLEN_HI = 3'd2;
    localparam logic [2:0] PH_TLEN_LO = 3'd3;
    localparam logic [2:0] PH_TOPIC   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;

    localparam logic [3:0] TYPE_PUBLISH     = 4'd3;
    localparam logic [2:0] MAX_LENGTH_BYTES = 3'd4;

    logic [2:0]                   phase_reg,  phase_next;
    logic [mpd_pkg::NIB_W-1:0]    type_reg,   type_next;
    logic [mpd_pkg::NIB_W-1:0]    flags_reg,  flags_next;
    logic [mpd_pkg::RLEN_W-1:0]   acc_reg,    acc_next;
    logic [2:0]                   cnt_reg,    cnt_next;
    logic [mpd_pkg::RLEN_W-1:0]   left_reg,   left_next;
    logic [mpd_pkg::TLEN_W-1:0]   tlen_reg,   tlen_next;
    logic [mpd_pkg::TLEN_W-1:0]   tleft_reg,  tleft_next;

    logic [mpd_pkg::RLEN_W-1:0]   left_dec;
    logic [mpd_pkg::TLEN_W-1:0]   tleft_dec;
    logic [mpd_pkg::RLEN_W-1:0]   group_shifted;
    logic [mpd_pkg::TLEN_W-1:0]   tlen_lo_val;
    logic [mpd_pkg::ROLE_W-1:0]   role;
    logic                         pkt_end;
    logic [mpd_pkg::ERR_W-1:0]    err;

    logic                         pkt_done;
    logic                         topic_fits;
    logic                         in_body;

    assign left_dec    = left_reg - 28'd1;
    assign tleft_dec   = tleft_reg - 16'd1;
    assign tlen_lo_val = {tlen_reg[15:8], rx_byte};

    // Place the 7 data bits of a length byte at its group position.
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    group_shifted = {21'd0, rx_byte[6:0]};
            2'd1:    group_shifted = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    group_shifted = {7'd0, rx_byte[6:0], 14'd0};
            default: group_shifted = {rx_byte[6:0], 21'd0};
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        role       = mpd_pkg::ROLE_FIRST;
        pkt_end    = 1'b0;
        err        = mpd_pkg::ERR_NONE;

        unique case (phase_reg)
            PH_LEN: begin
                role = mpd_pkg::ROLE_LENGTH;
                if (!cnt_reg[2]) begin
                    acc_next = acc_reg + group_shifted;
                end
                cnt_next = cnt_reg + 3'd1;
                if (rx_byte[7]) begin
                    if (cnt_next >= MAX_LENGTH_BYTES) begin
                        err        = mpd_pkg::ERR_BAD_LENGTH;
                        phase_next = PH_FIRST;
                    end
                end else begin
                    left_next = acc_next;
                    if (acc_next == '0) begin
                        pkt_end    = 1'b1;
                        phase_next = PH_FIRST;
                    end else if (type_reg == TYPE_PUBLISH) begin
                        phase_next = PH_TLEN_HI;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_TLEN_HI: begin
                role      = mpd_pkg::ROLE_TLEN;
                left_next = left_dec;
                tlen_next = {rx_byte, 8'd0};
                if (left_dec == '0) begin
                    err        = mpd_pkg::ERR_TOPIC_OVER;
                    phase_next = PH_FIRST;
                end else begin
                    phase_next = PH_TLEN_LO;
                end
            end
            PH_TLEN_LO: begin
                role       = mpd_pkg::ROLE_TLEN;
                left_next  = left_dec;
                tlen_next  = tlen_lo_val;
                tleft_next = tlen_lo_val;
                if ({12'd0, tlen_lo_val} > left_dec) begin
                    err        = mpd_pkg::ERR_TOPIC_OVER;
                    phase_next = PH_FIRST;
                end else if (tlen_lo_val == '0) begin
                    pkt_end    = (left_dec == '0);
                    phase_next = (left_dec == '0) ? PH_FIRST : PH_PAYLOAD;
                end else begin
                    phase_next = PH_TOPIC;
                end
            end
            PH_TOPIC: begin
                role       = mpd_pkg::ROLE_TOPIC;
                left_next  = left_dec;
                tleft_next = tleft_dec;
                if (tleft_dec == '0 || left_dec == '0) begin
                    pkt_end    = (left_dec == '0);
                    phase_next = (left_dec == '0) ? PH_FIRST : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role       = mpd_pkg::ROLE_PAYLOAD;
                left_next  = left_dec;
                pkt_end    = (left_dec == '0);
                phase_next = (left_dec == '0) ? PH_FIRST : PH_PAYLOAD;
            end
            PH_BODY: begin
                role       = mpd_pkg::ROLE_BODY;
                left_next  = left_dec;
                pkt_end    = (left_dec == '0);
                phase_next = (left_dec == '0) ? PH_FIRST : PH_BODY;
            end
            default: begin
                // First byte, also resync from any unused code.
                role       = mpd_pkg::ROLE_FIRST;
                type_next  = rx_byte[7:4];
                flags_next = rx_byte[3:0];
                acc_next   = '0;
                cnt_next   = '0;
                left_next  = '0;
                tlen_next  = '0;
                tleft_next = '0;
                phase_next = PH_LEN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            type_reg  <= '0;
            flags_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            tlen_reg  <= '0;
            tleft_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            flags_reg <= flags_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
        end
    end

    always_comb begin
        result.byte_role        = role;
        result.packet_type      = type_next;
        result.header_flags     = flags_next;
        result.remaining_length = acc_next;
        result.topic_length     = tlen_next;
        result.packet_end       = pkt_end;
        result.error_code       = err;
    end

    assign pkt_done   = pkt_end || (err != mpd_pkg::ERR_NONE);
    assign topic_fits = ({12'd0, tleft_reg} <= left_reg) && (tleft_reg != '0);
    assign in_body    = (phase_reg == PH_PAYLOAD) || (phase_reg == PH_BODY) ||
                        (phase_reg == PH_TLEN_LO);

    `MPD_ASSERT_NEXT(a_resync_after_end, step && pkt_done, phase_reg == PH_FIRST)
    `MPD_ASSERT_ALWAYS(a_count_bounded, cnt_reg <= MAX_LENGTH_BYTES)
    `MPD_ASSERT_SAME(a_topic_fits, phase_reg == PH_TOPIC, topic_fits)
    `MPD_ASSERT_SAME(a_body_nonempty, in_body, left_reg != '0)
    `MPD_ASSERT_SAME(a_no_end_on_error, err != mpd_pkg::ERR_NONE, !pkt_end)

endmodule

/* rtl/mpd_out_stage.sv */
module mpd_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  mpd_pkg::result_t               result,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mpd_pkg::TDATA_W-1:0]    m_tdata,
    output logic [mpd_pkg::TUSER_W-1:0]    m_tuser,
    output logic                           m_tlast
);

    logic             valid_reg;
    logic             valid_next;
    mpd_pkg::result_t res_reg;

    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.topic_length, res_reg.remaining_length,
                       res_reg.header_flags, res_reg.packet_type};
    assign m_tuser  = {res_reg.error_code, res_reg.byte_role};
    assign m_tlast  = res_reg.packet_end;

endmodule

/* rtl/mqtt_packet_deframer_unit.sv */
// MQTT 3.1.1 packet deframer. Feed the received byte stream one byte per
// transfer on the s_ side; every byte gives exactly one result transfer on the
// m_ side that tells its role in the control packet (first byte, remaining
// length byte, PUBLISH topic length byte, topic byte, payload byte or other
// body byte), the packet type and flag nibbles, the remaining length decoded
// so far, the PUBLISH topic length, an end-of-packet mark on m_tlast and an
// error code. A remaining length field longer than four bytes, or a PUBLISH
// topic that does not fit in the packet, is flagged on the offending byte and
// the next byte is taken as a new first byte; an error never carries m_tlast.
// Throughput is one byte per clock with no gaps between packets while
// m_tready stays high. A byte that transfers sits in the input register;
// when the result register is free or is being drained, the parse logic
// with its state registers moves it into the result register and m_tvalid
// rises. While a result waits on m_tready the held byte cannot advance, and
// once the input register is full s_tready drops, so a stall on the output
// side holds the input side as well.
module mqtt_packet_deframer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Received byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mpd_pkg::RX_W-1:0]      s_tdata,   // [7:0] rx_byte
    // Per-byte parse results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] packet_type, [7:4] header_flags, [35:8] remaining_length,
    // [51:36] topic_length, [55:52] zero
    output logic [mpd_pkg::TDATA_W-1:0]   m_tdata,
    output logic [mpd_pkg::TUSER_W-1:0]   m_tuser,   // [2:0] byte_role, [4:3] error_code
    output logic                          m_tlast    // packet_end
);

    logic                     byte_valid;
    logic [mpd_pkg::RX_W-1:0] byte_data;
    logic                     advance;
    mpd_pkg::result_t         parse_result;

    // Move the held byte through the parser whenever the result slot is free
    // or is being drained in this cycle.
    assign advance = byte_valid && (!m_tvalid || m_tready);

    mpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // State registers update only on advance, so every byte is parsed once.
    mpd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (byte_data),
        .result  (parse_result)
    );

    mpd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (parse_result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/mqtt_packet_deframer_checker.sv */
`timescale 1ns / 1ps
module mqtt_packet_deframer_checker #(
    parameter logic [3:0] PUBLISH_TYPE = 4'd3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [mpd_pkg::RX_W-1:0]    s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [mpd_pkg::TDATA_W-1:0] m_tdata,
    input  logic [mpd_pkg::TUSER_W-1:0] m_tuser,
    input  logic                        m_tlast,
    output int                          mismatches,
    output int                          reports_due,
    output int                          results_checked,
    output int                          packet_ends,
    output int                          error_bytes
);
    import mpd_pkg::*;

    localparam int MAX_LEN_BYTES = 4;
    localparam int DUE_DEPTH     = 64;

    typedef enum logic [2:0] {
        AT_FIRST,
        AT_LENGTH,
        AT_TLEN_HI,
        AT_TLEN_LO,
        AT_TOPIC,
        AT_PAYLOAD,
        AT_BODY
    } parse_phase_e;

    parse_phase_e      phase;
    logic [NIB_W-1:0]  pkt_type;
    logic [NIB_W-1:0]  pkt_flags;
    logic [RLEN_W-1:0] rlen_acc;
    logic [2:0]        len_groups;
    logic [RLEN_W-1:0] body_left;
    logic [TLEN_W-1:0] topic_len;
    logic [TLEN_W-1:0] topic_left;

    // Expected results in input order, held in a ring.
    result_t due_ring[DUE_DEPTH];
    int      due_wr;
    int      due_rd;

    // End the packet when the body is used up, else move on to next_phase.
    function automatic logic body_finished(input parse_phase_e next_phase);
        if (body_left == '0) begin
            phase = AT_FIRST;
            return 1'b1;
        end
        phase = next_phase;
        return 1'b0;
    endfunction

    function automatic result_t parse_rx_byte(input logic [RX_W-1:0] b);
        result_t     r;
        logic [31:0] grp;
        r = '0;
        case (phase)
            AT_LENGTH: begin
                r.byte_role = ROLE_LENGTH;
                if (len_groups < 3'd4) begin
                    grp = {25'd0, b[6:0]} << (7 * len_groups);
                    rlen_acc = rlen_acc + grp[RLEN_W-1:0];
                end
                len_groups = len_groups + 3'd1;
                if (b[7]) begin
                    if (len_groups >= MAX_LEN_BYTES) begin
                        r.error_code = ERR_BAD_LENGTH;
                        phase = AT_FIRST;
                    end
                end else begin
                    body_left = rlen_acc;
                    if (body_left == '0) begin
                        r.packet_end = 1'b1;
                        phase = AT_FIRST;
                    end else if (pkt_type == PUBLISH_TYPE) begin
                        phase = AT_TLEN_HI;
                    end else begin
                        phase = AT_BODY;
                    end
                end
            end
            AT_TLEN_HI: begin
                r.byte_role = ROLE_TLEN;
                body_left = body_left - 1'b1;
                topic_len = {b, 8'h00};
                if (body_left == '0) begin
                    r.error_code = ERR_TOPIC_OVER;
                    phase = AT_FIRST;
                end else begin
                    phase = AT_TLEN_LO;
                end
            end
            AT_TLEN_LO: begin
                r.byte_role = ROLE_TLEN;
                body_left = body_left - 1'b1;
                topic_len = {topic_len[15:8], b};
                topic_left = topic_len;
                if (RLEN_W'(topic_len) > body_left) begin
                    r.error_code = ERR_TOPIC_OVER;
                    phase = AT_FIRST;
                end else if (topic_len == '0) begin
                    r.packet_end = body_finished(AT_PAYLOAD);
                end else begin
                    phase = AT_TOPIC;
                end
            end
            AT_TOPIC: begin
                r.byte_role = ROLE_TOPIC;
                body_left = body_left - 1'b1;
                topic_left = topic_left - 1'b1;
                if (topic_left == '0 || body_left == '0)
                    r.packet_end = body_finished(AT_PAYLOAD);
            end
            AT_PAYLOAD: begin
                r.byte_role = ROLE_PAYLOAD;
                body_left = body_left - 1'b1;
                r.packet_end = body_finished(AT_PAYLOAD);
            end
            AT_BODY: begin
                r.byte_role = ROLE_BODY;
                body_left = body_left - 1'b1;
                r.packet_end = body_finished(AT_BODY);
            end
            default: begin
                r.byte_role = ROLE_FIRST;
                pkt_type = b[7:4];
                pkt_flags = b[3:0];
                rlen_acc = '0;
                len_groups = '0;
                body_left = '0;
                topic_len = '0;
                topic_left = '0;
                phase = AT_LENGTH;
            end
        endcase
        r.packet_type = pkt_type;
        r.header_flags = pkt_flags;
        r.remaining_length = rlen_acc;
        r.topic_length = topic_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, results_checked, what, got, want);
        mismatches++;
    endtask

    // Predict the result of an accepted byte and queue it.
    task automatic expect_byte(input logic [RX_W-1:0] b);
        result_t r;
        r = parse_rx_byte(b);
        if (due_wr - due_rd >= DUE_DEPTH) begin
            report_mismatch("bytes in flight", 32'(due_wr - due_rd), 32'(DUE_DEPTH));
        end else begin
            due_ring[due_wr % DUE_DEPTH] = r;
            due_wr++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (due_wr == due_rd) begin
            report_mismatch("result with no byte pending, tuser", 32'(m_tuser), 32'd0);
        end else begin
            want = due_ring[due_rd % DUE_DEPTH];
            due_rd++;
            if (m_tuser[ROLE_W-1:0] != want.byte_role)
                report_mismatch("byte_role", 32'(m_tuser[ROLE_W-1:0]), 32'(want.byte_role));
            if (m_tuser[ROLE_W +: ERR_W] != want.error_code)
                report_mismatch("error_code", 32'(m_tuser[ROLE_W +: ERR_W]),
                                32'(want.error_code));
            if (m_tdata[0 +: NIB_W] != want.packet_type)
                report_mismatch("packet_type", 32'(m_tdata[0 +: NIB_W]),
                                32'(want.packet_type));
            if (m_tdata[NIB_W +: NIB_W] != want.header_flags)
                report_mismatch("header_flags", 32'(m_tdata[NIB_W +: NIB_W]),
                                32'(want.header_flags));
            if (m_tdata[8 +: RLEN_W] != want.remaining_length)
                report_mismatch("remaining_length", 32'(m_tdata[8 +: RLEN_W]),
                                32'(want.remaining_length));
            if (m_tdata[8+RLEN_W +: TLEN_W] != want.topic_length)
                report_mismatch("topic_length", 32'(m_tdata[8+RLEN_W +: TLEN_W]),
                                32'(want.topic_length));
            if (m_tdata[TDATA_W-1:8+RLEN_W+TLEN_W] != '0)
                report_mismatch("tdata pad", 32'(m_tdata[TDATA_W-1:8+RLEN_W+TLEN_W]), 32'd0);
            if (m_tlast != want.packet_end)
                report_mismatch("packet_end", 32'(m_tlast), 32'(want.packet_end));
        end
        results_checked++;
        if (m_tlast)
            packet_ends++;
        if (m_tuser[ROLE_W +: ERR_W] != ERR_NONE)
            error_bytes++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = AT_FIRST;
            pkt_type = '0;
            pkt_flags = '0;
            rlen_acc = '0;
            len_groups = '0;
            body_left = '0;
            topic_len = '0;
            topic_left = '0;
            due_wr = 0;
            due_rd = 0;
        end else begin
            if (s_tvalid && s_tready)
                expect_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
        reports_due <= due_wr - due_rd;
    end

endmodule

/* tb/mqtt_packet_deframer_unit_tb.sv */
`timescale 1ns / 1ps
module mqtt_packet_deframer_unit_tb;
    import mpd_pkg::*;

    localparam logic [3:0] PUBLISH_TYPE = 4'd3;
    localparam int TOTAL_BYTES = 830;      // directed bytes plus about 800 random ones
    localparam int QUIET_TAIL  = 120;      // last bytes go without gaps or stalls
    localparam int CYCLE_LIMIT = 500000;   // far above the slowest correct run
    localparam int SETTLE      = 8;        // extra wait once no results are due

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [RX_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;

    int mismatches;
    int reports_due;
    int results_checked;
    int packet_ends;
    int error_bytes;

    int bytes_sent   = 0;
    int packets_sent = 0;
    int cycles       = 0;
    int gap_pct      = 0;   // chance per byte that the source opens an idle burst
    int stall_pct    = 0;   // chance per cycle that the sink opens a stall burst

    mqtt_packet_deframer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mqtt_packet_deframer_checker #(
        .PUBLISH_TYPE (PUBLISH_TYPE)
    ) parse_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .reports_due     (reports_due),
        .results_checked (results_checked),
        .packet_ends     (packet_ends),
        .error_bytes     (error_bytes)
    );

    always #10 aclk = ~aclk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycles, reports_due);
            $display("Some tests failed");
            $finish;
        end
    end

    // Sink: hold m_tready low for random bursts, release it otherwise.
    always begin
        @(posedge aclk);
        if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    // Offer one byte, maybe after an idle burst, and hold it until the transfer.
    task automatic send_byte(input logic [RX_W-1:0] b);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Remaining length: 7-bit groups, low group first, bit 7 flags another byte.
    // Sometimes pad with zero groups; a longer form of the same value is legal.
    task automatic send_length(input int unsigned len);
        int groups;
        int total;
        groups = 1;
        while (groups < 4 && (len >> (7 * groups)) != 0)
            groups++;
        total = groups;
        if ($urandom_range(0, 3) == 0)
            total = groups + $urandom_range(0, 4 - groups);
        for (int i = 0; i < total; i++)
            send_byte({i < total - 1, 7'((len >> (7 * i)) & 32'h7f)});
    endtask

    // Well-formed PUBLISH: topic length, topic bytes, payload bytes.
    task automatic send_publish(input logic [3:0] flags, input logic [15:0] topic_len,
                                input int unsigned payload_len);
        send_byte({PUBLISH_TYPE, flags});
        send_length(2 + topic_len + payload_len);
        send_byte(topic_len[15:8]);
        send_byte(topic_len[7:0]);
        repeat (topic_len) send_byte(8'($urandom));
        repeat (payload_len) send_byte(8'($urandom));
        packets_sent++;
    endtask

    // Any other packet type: an opaque body.
    task automatic send_plain(input logic [3:0] kind, input logic [3:0] flags,
                              input int unsigned body_len);
        send_byte({kind, flags});
        send_length(body_len);
        repeat (body_len) send_byte(8'($urandom));
        packets_sent++;
    endtask

    initial begin
        logic [RX_W-1:0] directed_bytes[$];
        logic [3:0]      kind;
        logic [15:0]     topic_len;
        int              body_len;
        int              pick;

        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_bytes = {
            // 4-byte length field of value zero: accepted, ends the packet
            8'hE0, 8'h80, 8'h80, 8'h80, 8'h00,
            // length field runs past 4 bytes: error on the 4th, all-ones length
            8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            // PUBLISH body ends on the first topic length byte
            8'h30, 8'h01, 8'hAB,
            // topic length larger than what is left of the body
            8'h3B, 8'h03, 8'h00, 8'h05,
            // PUBLISH with empty topic and no payload
            8'h31, 8'h02, 8'h00, 8'h00,
            // QoS 1 PUBLISH: body past the topic is all payload
            8'h32, 8'h06, 8'h00, 8'h02, 8'h61, 8'h62, 8'h12, 8'h34,
            // non-PUBLISH packet with a one-byte body
            8'hA2, 8'h01, 8'h7E
        };
        gap_pct   = 8;
        stall_pct = 8;
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // Mostly well-formed packets with random content, mixed with broken ones.
        while (bytes_sent < TOTAL_BYTES) begin
            if (bytes_sent >= TOTAL_BYTES - QUIET_TAIL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 4 * $urandom_range(0, 3);
                stall_pct = 4 * $urandom_range(0, 3);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_publish(4'($urandom), 16'($urandom_range(0, 8)), $urandom_range(0, 10));
            end else if (pick < 57) begin
                // topic long enough to use the high topic length byte
                send_publish(4'($urandom), 16'($urandom_range(256, 300)),
                             $urandom_range(0, 40));
            end else if (pick < 78) begin
                do kind = 4'($urandom); while (kind == PUBLISH_TYPE);
                if (pick < 75)
                    send_plain(kind, 4'($urandom), $urandom_range(0, 12));
                else
                    send_plain(kind, 4'($urandom), $urandom_range(100, 200));
            end else if (pick < 85) begin
                // length field that never stops: dropped on its 4th byte
                send_byte(8'($urandom));
                repeat (4) send_byte({1'b1, 7'($urandom)});
                packets_sent++;
            end else if (pick < 92) begin
                // PUBLISH cut off inside the topic length
                send_byte({PUBLISH_TYPE, 4'($urandom)});
                send_length(1);
                send_byte(8'($urandom));
                packets_sent++;
            end else begin
                // topic length overruns the body: dropped on the low byte
                body_len  = $urandom_range(2, 7);
                topic_len = 16'(body_len - 2 + $urandom_range(1, 300));
                send_byte({PUBLISH_TYPE, 4'($urandom)});
                send_length(body_len);
                send_byte(topic_len[15:8]);
                send_byte(topic_len[7:0]);
                packets_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain: let the last transfer reach the checker, then wait out the pipeline.
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Fed %0d bytes in %0d packets, mixing clean PUBLISH and other types with",
                 bytes_sent, packets_sent);
        $display("broken lengths and topics; checked %0d results (%0d ends, %0d errors)",
                 results_checked, packet_ends, error_bytes);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
